// ----- design/smd_pkg.sv -----
// Shared types and constants for the SLIP message deframer.
// No dependencies; used by every other design file except smd_if.
package smd_pkg;

  localparam int unsigned MsgLen    = 5;
  localparam int unsigned CntW      = 3;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned PtrW      = 1;
  localparam int unsigned FifoCntW  = 2;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic [7:0] EndCodeRst      = 8'd192;
  localparam logic [7:0] EscCodeRst      = 8'd219;
  localparam logic [7:0] EscEndCodeRst   = 8'd220;
  localparam logic [7:0] EscEscCodeRst   = 8'd221;
  localparam logic [7:0] DataFlagMaskRst = 8'd128;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_END_CODE       = 3'd0,
    CFG_ESC_CODE       = 3'd1,
    CFG_ESC_END_CODE   = 3'd2,
    CFG_ESC_ESC_CODE   = 3'd3,
    CFG_DATA_FLAG_MASK = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] end_code;
    logic [7:0] esc_code;
    logic [7:0] esc_end_code;
    logic [7:0] esc_esc_code;
    logic [7:0] data_flag_mask;
  } cfg_t;

  // Classified byte handed from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
    logic       is_esc;
    logic       is_esc_end;
    logic       is_esc_esc;
  } tok_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic [CntW-1:0] byte_cnt;
    logic            esc_pending;
  } back_stat_t;

endpackage

// ----- design/smd_if.sv -----
// Valid/ready channel interfaces for received bytes and decoded messages.
// Depends on nothing.
interface smd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_last;

  modport source (output valid, output rx_byte, output chunk_last, input ready);
  modport sink   (input valid, input rx_byte, input chunk_last, output ready);
endinterface

interface smd_msg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  msg_group;
  logic [15:0] msg_address;
  logic [15:0] msg_data;

  modport source (output valid, output msg_group, output msg_address, output msg_data,
                  input ready);
  modport sink   (input valid, input msg_group, input msg_address, input msg_data,
                  output ready);
endinterface

// ----- design/smd_front.sv -----
// Front end: accepts received bytes and tags them against the framing codes.
// Depends on smd_pkg and smd_byte_if.
module smd_front (
  smd_byte_if.sink      rx_i,
  input  smd_pkg::cfg_t cfg_i,
  input  logic          fifo_full_i,
  output logic          push_o,
  output smd_pkg::tok_t tok_o
);

  assign rx_i.ready = !fifo_full_i;
  assign push_o     = rx_i.valid && !fifo_full_i;

  always_comb begin
    tok_o.data       = rx_i.rx_byte;
    tok_o.is_end     = (rx_i.rx_byte == cfg_i.end_code);
    tok_o.is_esc     = (rx_i.rx_byte == cfg_i.esc_code);
    tok_o.is_esc_end = (rx_i.rx_byte == cfg_i.esc_end_code);
    tok_o.is_esc_esc = (rx_i.rx_byte == cfg_i.esc_esc_code);
  end

endmodule

// ----- design/smd_fifo.sv -----
// Two-entry token queue between the front and back ends.
// Depends on smd_pkg.
module smd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  smd_pkg::tok_t       tok_i,
  input  logic                pop_i,
  output smd_pkg::tok_t       tok_o,
  output smd_pkg::fifo_stat_t stat_o
);

  smd_pkg::tok_t                   mem_q [smd_pkg::FifoDepth];
  logic [smd_pkg::PtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [smd_pkg::PtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [smd_pkg::FifoCntW-1:0]    cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == smd_pkg::FifoCntW'(smd_pkg::FifoDepth));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign tok_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

endmodule

// ----- design/smd_back.sv -----
// Back end: escape/count state, frame buffer and registered message output.
// Depends on smd_pkg and smd_msg_if.
module smd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smd_pkg::cfg_t       cfg_i,
  input  logic                fifo_empty_i,
  input  smd_pkg::tok_t       tok_i,
  output logic                pop_o,
  output smd_pkg::back_stat_t stat_o,
  smd_msg_if.source           msg_o
);

  localparam logic [smd_pkg::CntW-1:0] Full = smd_pkg::CntW'(smd_pkg::MsgLen);

  logic                      esc_q, esc_d;
  logic [smd_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [7:0]                frame_q [smd_pkg::MsgLen];
  logic                      wr_en;
  logic [7:0]                wr_byte;
  logic                      out_valid_q, out_valid_d;
  logic                      load;
  logic [7:0]                group_q;
  logic [15:0]               addr_q, data_q;

  assign pop_o = !fifo_empty_i && (!out_valid_q || msg_o.ready);

  always_comb begin
    esc_d   = esc_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    wr_byte = tok_i.data;
    load    = 1'b0;
    if (pop_o) begin
      if (tok_i.is_end) begin
        load  = !esc_q && (cnt_q == Full);
        cnt_d = '0;
      end else if (cnt_q < Full) begin
        if (!esc_q && tok_i.is_esc) begin
          esc_d = 1'b1;
        end else if (esc_q) begin
          esc_d = 1'b0;
          if (tok_i.is_esc_end) begin
            wr_en   = 1'b1;
            wr_byte = cfg_i.end_code;
          end else if (tok_i.is_esc_esc) begin
            wr_en   = 1'b1;
            wr_byte = cfg_i.esc_code;
          end else begin
            cnt_d = '0;
          end
        end else begin
          wr_en = 1'b1;
        end
        if (wr_en) begin
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        esc_d = 1'b0;
        cnt_d = '0;
      end
    end
    out_valid_d = load ? 1'b1 : (msg_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      esc_q       <= esc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_q[cnt_q] <= wr_byte;
    end
    if (load) begin
      group_q <= frame_q[0] & ~cfg_i.data_flag_mask;
      addr_q  <= {frame_q[1], frame_q[2]};
      data_q  <= {frame_q[3], frame_q[4]};
    end
  end

  assign msg_o.valid       = out_valid_q;
  assign msg_o.msg_group   = group_q;
  assign msg_o.msg_address = addr_q;
  assign msg_o.msg_data    = data_q;

  assign stat_o.byte_cnt    = cnt_q;
  assign stat_o.esc_pending = esc_q;

endmodule

// ----- design/slip_message_deframer.sv -----
// SLIP message deframer top level: config registers, front end, queue, back end.
// A closing end byte is queued, then popped and registered as msg_o.valid.
// Throughput: one byte per cycle, limited by the single back-end state update,
// unless a waiting message stalls the back end; the queue holds up to two bytes.
// Reset (async, active low) clears the queue, escape flag, byte count and output
// valid, and loads the default framing codes; the frame buffer is not cleared.
module slip_message_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [7:0]                    cfg_wdata_i,
  smd_byte_if.sink                      rx_i,
  smd_msg_if.source                     msg_o
);

  smd_pkg::cfg_t       cfg_q;
  smd_pkg::tok_t       push_tok, head_tok;
  smd_pkg::fifo_stat_t fifo_stat;
  smd_pkg::back_stat_t back_stat;
  logic                push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.end_code       <= smd_pkg::EndCodeRst;
      cfg_q.esc_code       <= smd_pkg::EscCodeRst;
      cfg_q.esc_end_code   <= smd_pkg::EscEndCodeRst;
      cfg_q.esc_esc_code   <= smd_pkg::EscEscCodeRst;
      cfg_q.data_flag_mask <= smd_pkg::DataFlagMaskRst;
    end else if (cfg_we_i) begin
      unique case (smd_pkg::cfg_idx_e'(cfg_idx_i))
        smd_pkg::CFG_END_CODE:       cfg_q.end_code       <= cfg_wdata_i;
        smd_pkg::CFG_ESC_CODE:       cfg_q.esc_code       <= cfg_wdata_i;
        smd_pkg::CFG_ESC_END_CODE:   cfg_q.esc_end_code   <= cfg_wdata_i;
        smd_pkg::CFG_ESC_ESC_CODE:   cfg_q.esc_esc_code   <= cfg_wdata_i;
        smd_pkg::CFG_DATA_FLAG_MASK: cfg_q.data_flag_mask <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  smd_front u_front (
    .rx_i        (rx_i),
    .cfg_i       (cfg_q),
    .fifo_full_i (fifo_stat.full),
    .push_o      (push),
    .tok_o       (push_tok)
  );

  smd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .tok_i  (push_tok),
    .pop_i  (pop),
    .tok_o  (head_tok),
    .stat_o (fifo_stat)
  );

  smd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fifo_empty_i (fifo_stat.empty),
    .tok_i        (head_tok),
    .pop_o        (pop),
    .stat_o       (back_stat),
    .msg_o        (msg_o)
  );

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.byte_cnt <= smd_pkg::CntW'(smd_pkg::MsgLen))
    else $error("byte count beyond message length");

  a_fifo_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("queue both full and empty");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("pop from empty queue");

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_stat.full)
    else $error("push into full queue");
`endif

endmodule
